// File: rtl/ppab_pkg.sv
// Shared types, codes and constants for the parallel-port bridge front end.
// Used by rtl/parallel_port_atapi_bridge_frontend_core.sv; depends on nothing.
package ppab_pkg;

    localparam int REG_COUNT = 32;

    typedef enum logic [1:0] {
        OP_DATA_WR = 2'd0,
        OP_CTRL_WR = 2'd1,
        OP_STAT_RD = 2'd2,
        OP_CTRL_RD = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        MS_IDLE = 3'b001,
        MS_RUN  = 3'b010,
        MS_CMD  = 3'b100
    } t_match_state;

    typedef enum logic [2:0] {
        BM_NONE  = 3'b001,
        BM_READ  = 3'b010,
        BM_WRITE = 3'b100
    } t_block_mode;

    typedef struct packed {
        t_op        op;
        logic [7:0] value;
        logic [7:0] drive_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_value;
        logic       stream_out_valid;
        logic [7:0] stream_out_byte;
        logic       stream_in_taken;
        logic       link_connected;
    } t_out_item;

    localparam logic [2:0] PRE_LEN     = 3'd7;
    localparam logic [7:0] CMD_CONNECT = 8'hE0;
    localparam logic [7:0] CMD_DISCON  = 8'h30;
    localparam logic [7:0] CHK_A       = 8'hB8;
    localparam logic [7:0] CHK_B       = 8'h58;
    localparam logic [7:0] CHK_C       = 8'hF0;
    localparam logic [7:0] IDLE_STATUS = 8'h38;
    localparam logic [7:0] TAG_MASK    = 8'h60;
    localparam logic [7:0] REG_DEVCTL  = 8'h16;
    localparam logic [7:0] REG_STREAM  = 8'h07;
    localparam logic [7:0] SIG_LO      = 8'h14;
    localparam logic [7:0] SIG_HI      = 8'hEB;
    localparam logic [7:0] RDY_DSC     = 8'h50;

    localparam logic [7:0] CTRL_INIT_REL = 8'h01;
    localparam logic [7:0] CTRL_RD_ARM   = 8'h03;
    localparam logic [7:0] CTRL_HI_NIB   = 8'h04;
    localparam logic [7:0] CTRL_WR_ARM   = 8'h05;
    localparam logic [7:0] CTRL_WR_END   = 8'h07;

    // unlock preamble, index 7 and up never matches
    function automatic logic [7:0] preamble_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h22;
            3'd1:    b = 8'hAA;
            3'd2:    b = 8'h55;
            3'd3:    b = 8'h00;
            3'd4:    b = 8'hFF;
            3'd5:    b = 8'h87;
            3'd6:    b = 8'h78;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// File: rtl/parallel_port_atapi_bridge_frontend_core.sv
// Top level of the parallel-port bridge front end: input register, access decode,
// unlock matcher, register file and result register. Depends on rtl/ppab_pkg.sv.

// Each host port access (data write, control write, status read, control read)
// is one transfer in and gives one result transfer out. An access sits in the
// input register while the decode and state update run, then lands in the
// result register: one access per cycle sustained while the output is ready.
// The input register keeps taking transfers while a result waits downstream, and
// the block only stalls once both registers are full. The 32-byte register file
// lives in flops and is cleared by reset.
module parallel_port_atapi_bridge_frontend_core #(
    parameter int REG_COUNT = ppab_pkg::REG_COUNT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ppab_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ppab_pkg::t_out_item o_out_data
);

    localparam int REG_AW = $clog2(REG_COUNT);
    localparam logic [REG_AW-1:0] IDX_RDY = REG_AW'((8'h18 + 8'd7) & 8'(REG_COUNT - 1));
    localparam logic [REG_AW-1:0] IDX_SLO = REG_AW'((8'h18 + 8'd4) & 8'(REG_COUNT - 1));
    localparam logic [REG_AW-1:0] IDX_SHI = REG_AW'((8'h18 + 8'd5) & 8'(REG_COUNT - 1));

    // pipeline registers
    logic                r_in_valid;
    ppab_pkg::t_in_item  r_in;
    logic                r_res_valid;
    ppab_pkg::t_out_item r_res;
    logic                advance;
    logic                process;

    // bridge state
    logic [7:0]               r_ctrl_pins,   n_ctrl_pins;
    logic [7:0]               r_status_pins, n_status_pins;
    ppab_pkg::t_match_state   r_match_state, n_match_state;
    logic [2:0]               r_match_pos,   n_match_pos;
    logic [7:0]               r_last_byte,   n_last_byte;
    logic                     r_dup_pending, n_dup_pending;
    logic [7:0]               r_pending_cmd, n_pending_cmd;
    logic                     r_connected,   n_connected;
    ppab_pkg::t_block_mode    r_block_mode,  n_block_mode;
    ppab_pkg::t_block_mode    r_block_armed, n_block_armed;
    logic                     r_block_high_next, n_block_high_next;
    logic [7:0]               r_block_byte,  n_block_byte;
    logic [7:0]               r_addressed_reg, n_addressed_reg;
    logic [7:0]               r_fetched_byte, n_fetched_byte;
    logic                     r_write_pending, n_write_pending;
    logic                     r_high_nibble_next, n_high_nibble_next;
    logic [7:0]               r_reg_file [REG_COUNT];

    logic                     rf_wr_en;
    logic                     rf_reload;
    logic [7:0]               rf_rd_data;
    logic                     reg_in_range;
    logic [7:0]               fetch;
    ppab_pkg::t_out_item      result;
    logic [7:0]               v;
    logic [7:0]               drv;

    assign advance    = !r_res_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || advance;
    assign process    = r_in_valid && advance;

    assign o_out_valid = r_res_valid;
    assign o_out_data  = r_res;

    assign v            = r_in.value;
    assign drv          = r_in.drive_byte;
    assign reg_in_range = r_addressed_reg < 8'(REG_COUNT);
    assign rf_rd_data   = r_reg_file[r_addressed_reg[REG_AW-1:0]];

    always_comb begin
        n_ctrl_pins        = r_ctrl_pins;
        n_status_pins      = r_status_pins;
        n_match_state      = r_match_state;
        n_match_pos        = r_match_pos;
        n_last_byte        = r_last_byte;
        n_dup_pending      = r_dup_pending;
        n_pending_cmd      = r_pending_cmd;
        n_connected        = r_connected;
        n_block_mode       = r_block_mode;
        n_block_armed      = r_block_armed;
        n_block_high_next  = r_block_high_next;
        n_block_byte       = r_block_byte;
        n_addressed_reg    = r_addressed_reg;
        n_fetched_byte     = r_fetched_byte;
        n_write_pending    = r_write_pending;
        n_high_nibble_next = r_high_nibble_next;
        rf_wr_en           = 1'b0;
        rf_reload          = 1'b0;
        fetch              = 8'h00;
        result             = '0;

        case (r_in.op)
            ppab_pkg::OP_DATA_WR: begin
                // unlock matcher, an immediate repeat is folded away
                if (r_dup_pending && v == r_last_byte) begin
                    n_dup_pending = 1'b0;
                end else begin
                    n_last_byte   = v;
                    n_dup_pending = 1'b1;
                    if (r_match_state == ppab_pkg::MS_CMD) begin
                        n_pending_cmd = v;
                        n_match_state = ppab_pkg::MS_IDLE;
                    end else if (r_match_pos != ppab_pkg::PRE_LEN &&
                                 v == ppab_pkg::preamble_byte(r_match_pos)) begin
                        n_match_pos   = r_match_pos + 3'd1;
                        n_match_state = ppab_pkg::MS_RUN;
                        case (n_match_pos)
                            3'd5:    n_status_pins = ppab_pkg::CHK_A;
                            3'd6:    n_status_pins = ppab_pkg::CHK_B;
                            3'd7: begin
                                n_status_pins = ppab_pkg::CHK_C;
                                n_match_state = ppab_pkg::MS_CMD;
                            end
                            default: ;
                        endcase
                    end else if (v == ppab_pkg::preamble_byte(3'd0)) begin
                        n_match_pos   = 3'd1;
                        n_match_state = ppab_pkg::MS_RUN;
                    end else begin
                        n_match_pos   = 3'd0;
                        n_match_state = ppab_pkg::MS_IDLE;
                    end
                end

                if (n_match_state == ppab_pkg::MS_IDLE && n_pending_cmd == 8'h00 &&
                    r_connected) begin
                    if (r_block_mode == ppab_pkg::BM_WRITE) begin
                        result.stream_out_valid = 1'b1;
                        result.stream_out_byte  = v;
                    end else if (r_block_mode == ppab_pkg::BM_READ) begin
                        if (v == 8'h00) begin
                            n_block_mode = ppab_pkg::BM_NONE;
                        end
                    end else if (r_write_pending) begin
                        n_write_pending = 1'b0;
                        if (reg_in_range) begin
                            rf_wr_en  = 1'b1;
                            rf_reload = (r_addressed_reg == ppab_pkg::REG_DEVCTL) && !v[2];
                        end
                    end else if (v == (ppab_pkg::TAG_MASK | ppab_pkg::REG_STREAM)) begin
                        n_block_armed = ppab_pkg::BM_WRITE;
                    end else if (v == ppab_pkg::REG_STREAM) begin
                        n_block_armed = ppab_pkg::BM_READ;
                    end else if ((v & ppab_pkg::TAG_MASK) != 8'h00) begin
                        n_addressed_reg = v & ~ppab_pkg::TAG_MASK;
                        n_write_pending = 1'b1;
                    end else begin
                        n_addressed_reg    = v;
                        n_high_nibble_next = 1'b0;
                    end
                end
            end

            ppab_pkg::OP_CTRL_WR: begin
                // rising nINIT commits the pending command
                if (!r_ctrl_pins[0] && v[0] && r_match_state == ppab_pkg::MS_IDLE &&
                    r_pending_cmd != 8'h00) begin
                    if (r_pending_cmd == ppab_pkg::CMD_CONNECT) begin
                        n_connected   = 1'b1;
                        n_status_pins = ppab_pkg::IDLE_STATUS;
                    end else if (r_pending_cmd == ppab_pkg::CMD_DISCON) begin
                        n_connected   = 1'b0;
                        n_status_pins = ppab_pkg::IDLE_STATUS;
                    end
                    n_pending_cmd = 8'h00;
                    n_match_pos   = 3'd0;
                end
                n_ctrl_pins = v;
                if (n_connected && r_block_armed == ppab_pkg::BM_WRITE &&
                    v == ppab_pkg::CTRL_WR_ARM) begin
                    n_block_mode  = ppab_pkg::BM_WRITE;
                    n_block_armed = ppab_pkg::BM_NONE;
                end else if (n_connected && r_block_armed == ppab_pkg::BM_READ &&
                             v == ppab_pkg::CTRL_RD_ARM) begin
                    n_block_mode      = ppab_pkg::BM_READ;
                    n_block_armed     = ppab_pkg::BM_NONE;
                    n_block_high_next = 1'b0;
                end else if (r_block_mode == ppab_pkg::BM_WRITE &&
                             v == ppab_pkg::CTRL_WR_END) begin
                    n_block_mode = ppab_pkg::BM_NONE;
                end else if (r_block_mode != ppab_pkg::BM_NONE) begin
                    // stream running, pins only
                end else if (n_connected && v == ppab_pkg::CTRL_INIT_REL) begin
                    n_match_state      = ppab_pkg::MS_IDLE;
                    n_match_pos        = 3'd0;
                    n_high_nibble_next = 1'b0;
                end else if (n_connected && v == ppab_pkg::CTRL_RD_ARM) begin
                    n_high_nibble_next = 1'b0;
                end else if (n_connected && v == ppab_pkg::CTRL_HI_NIB &&
                             n_pending_cmd == 8'h00) begin
                    n_high_nibble_next = 1'b1;
                end
            end

            ppab_pkg::OP_STAT_RD: begin
                if (r_match_state != ppab_pkg::MS_IDLE || !r_connected) begin
                    result.read_value = r_status_pins;
                end else if (r_block_mode == ppab_pkg::BM_READ) begin
                    if (r_block_high_next) begin
                        n_block_high_next = 1'b0;
                        result.read_value = {r_block_byte[7:4], 4'h0};
                    end else begin
                        n_block_byte           = drv;
                        n_block_high_next      = 1'b1;
                        result.stream_in_taken = 1'b1;
                        result.read_value      = {drv[3:0], 4'h0};
                    end
                end else if (!reg_in_range) begin
                    result.read_value = r_status_pins;
                end else begin
                    // low nibble read latches the byte, high nibble reuses it
                    fetch = r_high_nibble_next ? r_fetched_byte : rf_rd_data;
                    n_fetched_byte = fetch;
                    if (r_high_nibble_next) begin
                        result.read_value = {fetch[7:4], ppab_pkg::IDLE_STATUS[3:0]};
                    end else begin
                        result.read_value = {fetch[3:0], ppab_pkg::IDLE_STATUS[3:0]};
                    end
                end
            end

            ppab_pkg::OP_CTRL_RD: begin
                result.read_value = r_ctrl_pins;
            end

            default: ;
        endcase

        result.link_connected = n_connected;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_res_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
        if (process) begin
            r_res <= result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl_pins        <= 8'h00;
            r_status_pins      <= ppab_pkg::IDLE_STATUS;
            r_match_state      <= ppab_pkg::MS_IDLE;
            r_match_pos        <= 3'd0;
            r_last_byte        <= 8'h00;
            r_dup_pending      <= 1'b0;
            r_pending_cmd      <= 8'h00;
            r_connected        <= 1'b0;
            r_block_mode       <= ppab_pkg::BM_NONE;
            r_block_armed      <= ppab_pkg::BM_NONE;
            r_block_high_next  <= 1'b0;
            r_block_byte       <= 8'h00;
            r_addressed_reg    <= 8'h00;
            r_fetched_byte     <= 8'h00;
            r_write_pending    <= 1'b0;
            r_high_nibble_next <= 1'b0;
        end else if (process) begin
            r_ctrl_pins        <= n_ctrl_pins;
            r_status_pins      <= n_status_pins;
            r_match_state      <= n_match_state;
            r_match_pos        <= n_match_pos;
            r_last_byte        <= n_last_byte;
            r_dup_pending      <= n_dup_pending;
            r_pending_cmd      <= n_pending_cmd;
            r_connected        <= n_connected;
            r_block_mode       <= n_block_mode;
            r_block_armed      <= n_block_armed;
            r_block_high_next  <= n_block_high_next;
            r_block_byte       <= n_block_byte;
            r_addressed_reg    <= n_addressed_reg;
            r_fetched_byte     <= n_fetched_byte;
            r_write_pending    <= n_write_pending;
            r_high_nibble_next <= n_high_nibble_next;
        end
    end

    // register file; device-control release reloads the reset signature
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < REG_COUNT; i++) begin
                r_reg_file[i] <= 8'h00;
            end
        end else if (process && rf_reload) begin
            for (int i = 0; i < REG_COUNT; i++) begin
                r_reg_file[i] <= (REG_AW'(i) == IDX_RDY) ? ppab_pkg::RDY_DSC :
                                 (REG_AW'(i) == IDX_SLO) ? ppab_pkg::SIG_LO  :
                                 (REG_AW'(i) == IDX_SHI) ? ppab_pkg::SIG_HI  : 8'h00;
            end
        end else if (process && rf_wr_en) begin
            r_reg_file[r_addressed_reg[REG_AW-1:0]] <= v;
        end
    end

endmodule
